// File: src/ssc_pkg.sv
// shared types, constants and arithmetic steps for the sphere contact block
package ssc_pkg;

  localparam int SQ_LAT     = 32;
  localparam int DIV_LAT    = 33;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;
  localparam logic [32:0] PUSH_CAP = 33'h1_0000_0000;

  // one classified pair, as it travels from front to back
  typedef struct packed {
    logic              hit;
    logic [2:0][31:0]  a;
    logic [2:0]        neg;
    logic [2:0][32:0]  m;
    logic [30:0]       rb;
    logic [31:0]       s;
    logic [63:0]       lo;
    logic              zs;
    logic              zd;
  } item_t;

  // what the output stage still needs after the dividers
  typedef struct packed {
    logic              hit;
    logic [2:0][31:0]  a;
    logic [2:0]        neg;
    logic              zs;
    logic              zd;
  } tail_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [2:0][31:0]  contact;
    logic [2:0][31:0]  push;
  } result_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
  } sq_step_t;

  typedef struct packed {
    logic [31:0] rem;
    logic        qb;
  } div_step_t;

  function automatic sq_step_t sqrt_step(input logic [34:0] rem_in,
                                         input logic [31:0] root_in,
                                         input logic [1:0]  pair);
    sq_step_t    r;
    logic [34:0] t;
    logic [34:0] trial;
    t     = {rem_in[32:0], pair};
    trial = {1'b0, root_in, 2'b01};
    if (t >= trial) begin
      r.rem  = t - trial;
      r.root = {root_in[30:0], 1'b1};
    end else begin
      r.rem  = t;
      r.root = {root_in[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div_step_t div_step(input logic [31:0] rem_in,
                                         input logic        b,
                                         input logic [31:0] den);
    div_step_t   r;
    logic [32:0] t;
    logic [32:0] d;
    t = {rem_in, b};
    d = {1'b0, den};
    if (t >= d) begin
      r.rem = 32'(t - d);
      r.qb  = 1'b1;
    end else begin
      r.rem = t[31:0];
      r.qb  = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > SAT_MAX) r = SAT_MAX[31:0];
    else if (v < SAT_MIN) r = SAT_MIN[31:0];
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: src/ssc_front.sv
// front end: takes a request, forms center deltas and squares, classifies hit
module ssc_front import ssc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [2:0][31:0]   ca,
  input  logic [2:0][31:0]   cb,
  input  logic [30:0]        ra,
  input  logic [30:0]        rb,
  output logic               push,
  output item_t              item,
  output logic [1:0]         inflight
);

  logic              v1_r, v2_r;
  logic [2:0][31:0]  a1_r, a2_r;
  logic [2:0]        neg1_r, neg2_r;
  logic [2:0][32:0]  m1_r, m2_r;
  logic [30:0]       rb1_r, rb2_r;
  logic [31:0]       s1_r, s2_r;
  logic [2:0][65:0]  sq2_r;
  logic [63:0]       ss2_r;

  logic [2:0][32:0]  d_nxt;
  logic [2:0][32:0]  m_nxt;
  logic [65:0]       sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = {ca[i][31], ca[i]} - {cb[i][31], cb[i]};
      m_nxt[i] = d_nxt[i][32] ? 33'(-d_nxt[i]) : d_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
    end
    for (int i = 0; i < 3; i++) begin
      neg1_r[i] <= d_nxt[i][32];
      sq2_r[i]  <= m1_r[i] * m1_r[i];
    end
    a1_r   <= ca;
    m1_r   <= m_nxt;
    rb1_r  <= rb;
    s1_r   <= {1'b0, ra} + {1'b0, rb};
    a2_r   <= a1_r;
    neg2_r <= neg1_r;
    m2_r   <= m1_r;
    rb2_r  <= rb1_r;
    s2_r   <= s1_r;
    ss2_r  <= s1_r * s1_r;
  end

  assign sum = sq2_r[0] + sq2_r[1] + sq2_r[2];

  always_comb begin
    item.hit = (sum <= {2'b00, ss2_r});
    item.a   = a2_r;
    item.neg = neg2_r;
    item.m   = m2_r;
    item.rb  = rb2_r;
    item.s   = s2_r;
    item.lo  = sum[63:0];
    item.zs  = (s2_r == '0);
    item.zd  = (sum == '0);
  end

  assign push     = v2_r;
  assign inflight = {1'b0, v1_r} + {1'b0, v2_r};

endmodule

// File: src/ssc_queue.sv
// short queue of classified pairs between front and back
module ssc_queue import ssc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  item_t               wdata,
  input  logic                pop,
  output item_t               rdata,
  output logic                nonempty,
  output logic [Q_CNT_W-1:0]  count
);

  item_t                mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_r, rd_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
    end
    if (push) mem_r[wr_r] <= wdata;
  end

  assign rdata    = mem_r[rd_r];
  assign nonempty = (cnt_r != '0);
  assign count    = cnt_r;

endmodule

// File: src/ssc_sqrt.sv
// pipelined floor square root, one result bit per stage
module ssc_sqrt import ssc_pkg::*; (
  input  logic        clk,
  input  logic [63:0] v,
  output logic [31:0] root
);

  logic [34:0] rem_r  [SQ_LAT];
  logic [31:0] root_r [SQ_LAT];
  logic [63:0] val_r  [SQ_LAT];
  logic [34:0] rem_nxt  [SQ_LAT];
  logic [31:0] root_nxt [SQ_LAT];
  logic [63:0] val_nxt  [SQ_LAT];

  always_comb begin
    sq_step_t st;
    st          = sqrt_step('0, '0, v[63:62]);
    rem_nxt[0]  = st.rem;
    root_nxt[0] = st.root;
    val_nxt[0]  = {v[61:0], 2'b00};
    for (int k = 1; k < SQ_LAT; k++) begin
      st          = sqrt_step(rem_r[k-1], root_r[k-1], val_r[k-1][63:62]);
      rem_nxt[k]  = st.rem;
      root_nxt[k] = st.root;
      val_nxt[k]  = {val_r[k-1][61:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_LAT; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      val_r[k]  <= val_nxt[k];
    end
  end

  assign root = root_r[SQ_LAT-1];

endmodule

// File: src/ssc_div.sv
// pipelined restoring divider, one quotient bit per stage
module ssc_div import ssc_pkg::*; (
  input  logic        clk,
  input  logic [64:0] num,
  input  logic [31:0] den,
  output logic [32:0] quo
);

  logic [31:0] rem_r [DIV_LAT];
  logic [31:0] low_r [DIV_LAT];
  logic [31:0] den_r [DIV_LAT];
  logic [32:0] q_r   [DIV_LAT];
  logic [31:0] rem_nxt [DIV_LAT];
  logic [31:0] low_nxt [DIV_LAT];
  logic [32:0] q_nxt   [DIV_LAT];

  // quotient is known to fit in 33 bits, so the top bits seed the remainder
  always_comb begin
    div_step_t st;
    st         = div_step(num[64:33], num[32], den);
    rem_nxt[0] = st.rem;
    low_nxt[0] = num[31:0];
    q_nxt[0]   = {32'b0, st.qb};
    for (int k = 1; k < DIV_LAT; k++) begin
      st         = div_step(rem_r[k-1], low_r[k-1][31], den_r[k-1]);
      rem_nxt[k] = st.rem;
      low_nxt[k] = {low_r[k-1][30:0], 1'b0};
      q_nxt[k]   = {q_r[k-1][31:0], st.qb};
    end
  end

  always_ff @(posedge clk) begin
    den_r[0] <= den;
    for (int k = 0; k < DIV_LAT; k++) begin
      rem_r[k] <= rem_nxt[k];
      low_r[k] <= low_nxt[k];
      q_r[k]   <= q_nxt[k];
      if (k > 0) den_r[k] <= den_r[k-1];
    end
  end

  assign quo = q_r[DIV_LAT-1];

endmodule

// File: src/ssc_back.sv
// back end: distance root, contact and push divisions, saturation
module ssc_back import ssc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  item_t    in_item,
  output result_t  res
);

  logic               v0_r;
  item_t              e0_r;
  logic [SQ_LAT-1:0]  va_r;
  item_t              sa_r [SQ_LAT];
  logic               vl_r, vm_r;
  item_t              l_item_r, m_item_r;
  logic [31:0]        len_r, dist_l_r, dist_m_r;
  logic [2:0][63:0]   prodc_r, prodp_r;
  logic [DIV_LAT-1:0] vb_r;
  tail_t              sb_r [DIV_LAT];
  tail_t              tail_in;
  logic [31:0]        cdist;
  logic [2:0][32:0]   qc, qp;
  result_t            res_r;

  ssc_sqrt u_sqrt (.clk(clk), .v(e0_r.lo), .root(cdist));

  for (genvar i = 0; i < 3; i++) begin : g_axis
    ssc_div u_divc (
      .clk(clk),
      .num({1'b0, prodc_r[i]} + {34'b0, m_item_r.s[31:1]}),
      .den(m_item_r.s),
      .quo(qc[i])
    );
    ssc_div u_divp (
      .clk(clk),
      .num({1'b0, prodp_r[i]} + {34'b0, dist_m_r[31:1]}),
      .den(dist_m_r),
      .quo(qp[i])
    );
  end

  always_comb begin
    tail_in.hit = m_item_r.hit;
    tail_in.a   = m_item_r.a;
    tail_in.neg = m_item_r.neg;
    tail_in.zs  = m_item_r.zs;
    tail_in.zd  = m_item_r.zd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      va_r  <= '0;
      vl_r  <= 1'b0;
      vm_r  <= 1'b0;
      vb_r  <= '0;
      res_r.valid <= 1'b0;
    end else begin
      v0_r  <= in_valid;
      va_r  <= {va_r[SQ_LAT-2:0], v0_r};
      vl_r  <= va_r[SQ_LAT-1];
      vm_r  <= vl_r;
      vb_r  <= {vb_r[DIV_LAT-2:0], vm_r};
      res_r.valid <= vb_r[DIV_LAT-1];
    end
    e0_r     <= in_item;
    sa_r[0]  <= e0_r;
    for (int k = 1; k < SQ_LAT; k++) sa_r[k] <= sa_r[k-1];
    l_item_r <= sa_r[SQ_LAT-1];
    len_r    <= sa_r[SQ_LAT-1].s - cdist;
    dist_l_r <= cdist;
    m_item_r <= l_item_r;
    dist_m_r <= dist_l_r;
    // on a hit every delta magnitude is below 2^32, so the low word suffices
    for (int i = 0; i < 3; i++) begin
      prodc_r[i] <= l_item_r.m[i][31:0] * {1'b0, l_item_r.rb};
      prodp_r[i] <= l_item_r.m[i][31:0] * len_r;
    end
    sb_r[0] <= tail_in;
    for (int k = 1; k < DIV_LAT; k++) sb_r[k] <= sb_r[k-1];
  end

  always_ff @(posedge clk) begin
    logic signed [34:0] aext, c, p;
    logic [32:0]        qcap;
    res_r.hit <= sb_r[DIV_LAT-1].hit;
    for (int i = 0; i < 3; i++) begin
      aext = {{3{sb_r[DIV_LAT-1].a[i][31]}}, sb_r[DIV_LAT-1].a[i]};
      if (sb_r[DIV_LAT-1].zs) c = aext;
      else if (sb_r[DIV_LAT-1].neg[i]) c = aext + {2'b00, qc[i]};
      else c = aext - {2'b00, qc[i]};
      qcap = (qp[i] > PUSH_CAP) ? PUSH_CAP : qp[i];
      if (sb_r[DIV_LAT-1].zd) p = '0;
      else if (sb_r[DIV_LAT-1].neg[i]) p = -{2'b00, qcap};
      else p = {2'b00, qcap};
      if (sb_r[DIV_LAT-1].hit) begin
        res_r.contact[i] <= sat32(c);
        res_r.push[i]    <= sat32(p);
      end else begin
        res_r.contact[i] <= '0;
        res_r.push[i]    <= '0;
      end
    end
  end

  assign res = res_r;

endmodule

// File: src/sphere_sphere_contact_top.sv
// top level of the sphere pair contact test
// One sphere pair is taken per clock while busy is low and each result strobes
// out on out_valid in request order. It passes the 32-stage square root of the
// squared center distance and then the 33-stage dividers for the contact and
// push terms; every stage takes a new pair each cycle, so busy stays low in
// steady streaming. Results appear for a single cycle and must be captured then.
module sphere_sphere_contact_top import ssc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_a_center_x,
  input  logic signed [31:0] in_a_center_y,
  input  logic signed [31:0] in_a_center_z,
  input  logic [30:0]        in_a_radius,
  input  logic signed [31:0] in_b_center_x,
  input  logic signed [31:0] in_b_center_y,
  input  logic signed [31:0] in_b_center_z,
  input  logic [30:0]        in_b_radius,
  output logic               out_valid,
  output logic               out_hit,
  output logic signed [31:0] out_contact_x,
  output logic signed [31:0] out_contact_y,
  output logic signed [31:0] out_contact_z,
  output logic signed [31:0] out_push_x,
  output logic signed [31:0] out_push_y,
  output logic signed [31:0] out_push_z
);

  logic                take;
  logic                push;
  item_t               f_item, q_item;
  logic [1:0]          inflight;
  logic                q_nonempty;
  logic [Q_CNT_W-1:0]  q_count;
  result_t             res;
  logic [Q_CNT_W:0]    reserved;

  // queue slots already spoken for, counting pairs still in the front end
  assign reserved = {1'b0, q_count} + {{(Q_CNT_W-1){1'b0}}, inflight};
  assign busy     = (reserved >= (Q_CNT_W+1)'(Q_DEPTH));
  assign take     = start && !busy;

  ssc_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take),
    .ca({in_a_center_z, in_a_center_y, in_a_center_x}),
    .cb({in_b_center_z, in_b_center_y, in_b_center_x}),
    .ra(in_a_radius), .rb(in_b_radius),
    .push(push), .item(f_item), .inflight(inflight)
  );

  ssc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(f_item),
    .pop(q_nonempty), .rdata(q_item), .nonempty(q_nonempty), .count(q_count)
  );

  ssc_back u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(q_nonempty), .in_item(q_item), .res(res)
  );

  assign out_valid     = res.valid;
  assign out_hit       = res.hit;
  assign out_contact_x = res.contact[0];
  assign out_contact_y = res.contact[1];
  assign out_contact_z = res.contact[2];
  assign out_push_x    = res.push[0];
  assign out_push_y    = res.push[1];
  assign out_push_z    = res.push[2];

endmodule

// File: verif/testbench.sv
// self-checking testbench for the sphere pair contact block
module testbench;
  import ssc_pkg::*;

  typedef struct packed {
    logic signed [31:0] ax, ay, az;
    logic [30:0]        ra;
    logic signed [31:0] bx, by, bz;
    logic [30:0]        rb;
  } pair_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] cx, cy, cz;
    logic signed [31:0] px, py, pz;
  } contact_t;

  typedef struct packed {
    pair_t    p;
    logic     typed;
    contact_t res;
  } row_t;

  localparam int WATCH_LIMIT = 5000;
  localparam int N_RANDOM    = 1630;
  localparam logic signed [31:0] PMAX = 32'sh7fffffff;
  localparam logic signed [31:0] PMIN = 32'sh80000000;
  localparam logic [30:0]        RMAX = 31'h7fffffff;

  logic clk, rst_n, start, busy;
  pair_t drv;
  logic out_valid, out_hit;
  logic signed [31:0] out_contact_x, out_contact_y, out_contact_z;
  logic signed [31:0] out_push_x, out_push_y, out_push_z;

  contact_t expected_q[$];
  int errors = 0;
  int n_req = 0, n_res = 0, n_hits = 0, idle_cycles = 0;

  sphere_sphere_contact_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_center_x(drv.ax), .in_a_center_y(drv.ay), .in_a_center_z(drv.az),
    .in_a_radius(drv.ra),
    .in_b_center_x(drv.bx), .in_b_center_y(drv.by), .in_b_center_z(drv.bz),
    .in_b_radius(drv.rb),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_contact_x(out_contact_x), .out_contact_y(out_contact_y),
    .out_contact_z(out_contact_z),
    .out_push_x(out_push_x), .out_push_y(out_push_y), .out_push_z(out_push_z)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > longint'(PMAX)) return PMAX;
    if (v < longint'(PMIN)) return PMIN;
    return v[31:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic contact_t predict_contact(input pair_t p);
    contact_t    r;
    longint      a[3], d[3], cv[3], pv[3];
    logic [63:0] m[3];
    logic [66:0] dsq;
    logic [63:0] s, cdist, len, q;
    a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
    d[0] = a[0] - longint'(p.bx);
    d[1] = a[1] - longint'(p.by);
    d[2] = a[2] - longint'(p.bz);
    s = 64'(p.ra) + 64'(p.rb);
    dsq = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
      dsq += 67'(m[i]) * 67'(m[i]);
    end
    r = '0;
    if (dsq > 67'(s * s)) return r;
    r.hit = 1'b1;
    cdist = floor_root(dsq[63:0]);
    len = s - cdist;
    for (int i = 0; i < 3; i++) begin
      cv[i] = a[i];
      pv[i] = 0;
      // both radii zero leaves the contact at center a
      if (s != 0) begin
        q = (m[i] * 64'(p.rb) + s / 2) / s;
        cv[i] = d[i] < 0 ? a[i] + longint'(q) : a[i] - longint'(q);
      end
      // coincident centers give no push direction
      if (dsq != 0) begin
        q = (m[i] * len + cdist / 2) / cdist;
        if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
        pv[i] = d[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    r.cx = clamp32(cv[0]); r.cy = clamp32(cv[1]); r.cz = clamp32(cv[2]);
    r.px = clamp32(pv[0]); r.py = clamp32(pv[1]); r.pz = clamp32(pv[2]);
    return r;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int k;
    logic [31:0] span;
    k = $urandom_range(0, 9);
    p.ax = $urandom; p.ay = $urandom; p.az = $urandom; p.ra = 31'($urandom);
    p.bx = $urandom; p.by = $urandom; p.bz = $urandom; p.rb = 31'($urandom);
    if (k < 6) begin
      // nearby spheres with radii around the center distance
      span = 32'hffff_ffff >> $urandom_range(1, 28);
      p.bx = p.ax + ($urandom & span) - (span >> 1);
      p.by = p.ay + ($urandom & span) - (span >> 1);
      p.bz = p.az + ($urandom & span) - (span >> 1);
      p.ra = 31'($urandom & span);
      p.rb = 31'($urandom & span);
      if ($urandom_range(0, 7) == 0) p.ra = 0;
      if ($urandom_range(0, 7) == 0) p.rb = 0;
    end else if (k == 6) begin
      p.bx = p.ax; p.by = p.ay; p.bz = p.az;
    end else if (k == 7) begin
      p.ra = 0; p.rb = 0;
      if ($urandom_range(0, 1)) begin
        p.bx = p.ax; p.by = p.ay; p.bz = p.az;
      end
    end
    return p;
  endfunction

  task automatic idle_gap();
    int k, n;
    k = $urandom_range(0, 99);
    if (k < 60) n = 0;
    else if (k < 95) n = $urandom_range(1, 4);
    else n = $urandom_range(20, 90);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // drive one request and hold it until the block takes it
  task automatic send_pair(input pair_t p, input logic typed, input contact_t res);
    contact_t e;
    e = predict_contact(p);
    if (typed && e !== res) begin
      $error("typed row disagrees with predictor: expected %h got %h", res, e);
      errors++;
    end
    drv   <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(typed ? res : e);
    n_req++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] exp_v,
                             input logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    contact_t e;
    if (rst_n && out_valid) begin
      n_res++;
      if (expected_q.size() == 0) begin
        $error("result with no request waiting");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.hit !== out_hit) begin
          $error("hit mismatch: expected %0d actual %0d", e.hit, out_hit);
          errors++;
        end
        if (out_hit) n_hits++;
        check_field("contact_x", e.cx, out_contact_x);
        check_field("contact_y", e.cy, out_contact_y);
        check_field("contact_z", e.cz, out_contact_z);
        check_field("push_x", e.px, out_push_x);
        check_field("push_y", e.py, out_push_y);
        check_field("push_z", e.pz, out_push_z);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  row_t rows[$];

  function automatic row_t mk(input pair_t p, input logic typed, input contact_t res);
    row_t r;
    r.p = p; r.typed = typed; r.res = res;
    return r;
  endfunction

  initial begin
    contact_t none, z;
    none = '0;
    rst_n = 1'b0;
    start = 1'b0;
    drv   = '0;
    // all zero: both radii zero and coincident centers
    z = '0; z.hit = 1'b1;
    rows.push_back(mk('0, 1'b1, z));
    // far apart corners with zero radii
    rows.push_back(mk({PMAX, PMAX, PMAX, 31'd0, PMIN, PMIN, PMIN, 31'd0}, 1'b1, none));
    rows.push_back(mk({PMIN, PMIN, PMIN, 31'd0, PMAX, PMAX, PMAX, 31'd0}, 1'b1, none));
    // coincident centers, largest and zero radii: contact is a, no push
    z = '0; z.hit = 1'b1; z.cx = PMAX; z.cy = PMIN; z.cz = PMAX;
    rows.push_back(mk({PMAX, PMIN, PMAX, RMAX, PMAX, PMIN, PMAX, RMAX}, 1'b1, z));
    z.cx = 32'sd5; z.cy = -32'sd7; z.cz = 32'sd9;
    rows.push_back(mk({32'sd5, -32'sd7, 32'sd9, 31'd0, 32'sd5, -32'sd7, 32'sd9, 31'd0},
                      1'b1, z));
    // just missing along x
    rows.push_back(mk({32'sd0, 32'sd0, 32'sd0, 31'd65536, 32'sd131073, 32'sd0, 32'sd0,
                       31'd65536}, 1'b1, none));
    // the rest from the predictor
    rows.push_back(mk({32'sd0, 32'sd0, 32'sd0, 31'd65536, 32'sd131072, 32'sd0, 32'sd0,
                       31'd65536}, 1'b0, none));
    rows.push_back(mk({32'sd0, 32'sd0, 32'sd0, RMAX, PMAX, 32'sd0, 32'sd0, RMAX},
                      1'b0, none));
    rows.push_back(mk({PMAX, 32'sd0, 32'sd0, RMAX, PMIN, 32'sd0, 32'sd0, RMAX},
                      1'b0, none));
    rows.push_back(mk({PMIN, PMIN, PMIN, RMAX, PMAX, PMAX, PMAX, RMAX}, 1'b0, none));
    rows.push_back(mk({PMAX, PMAX, PMAX, RMAX, PMAX - 32'sd3, PMAX, PMAX, 31'd0},
                      1'b0, none));
    rows.push_back(mk({PMIN, PMIN, PMIN, 31'd0, PMIN + 32'sd1, PMIN, PMIN, RMAX},
                      1'b0, none));
    rows.push_back(mk({32'sd100, -32'sd200, 32'sd300, 31'd1000, -32'sd100, 32'sd200,
                       -32'sd300, 31'd1}, 1'b0, none));
    rows.push_back(mk({32'sd3, 32'sd4, 32'sd0, 31'd3, 32'sd0, 32'sd0, 32'sd0, 31'd2},
                      1'b0, none));
    rows.push_back(mk({-32'sd1, -32'sd1, -32'sd1, 31'd1, 32'sd1, 32'sd1, 32'sd1, 31'd1},
                      1'b0, none));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].res);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
      end else begin
        idle_gap();
      end
      send_pair(random_pair(), 1'b0, none);
    end
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d sphere pairs, checked %0d results, %0d of them hits",
             n_req, n_res, n_hits);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
